/* rtl/fbpa_pkg.sv */
// ----------------------------------------------------------------------------
// fbpa_pkg: shared types and constants for the fixed block pool allocator
// Holds field widths, operation and status codes, register indexes, the
// controller/datapath command and status structs, and size helpers.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  // Pool geometry
  localparam int MAX_BLOCKS = 256;
  localparam int QIDX_W     = $clog2(MAX_BLOCKS);
  localparam int ADDR_W     = 32;
  localparam int SIZE_W     = 17;
  localparam int RSIZE_W    = SIZE_W + 1;
  localparam int COUNT_W    = 9;
  // An in-range offset stays below rounded size times MAX_BLOCKS
  localparam int OFS_W      = RSIZE_W - 1 + QIDX_W;
  localparam int SPAN_W     = RSIZE_W + COUNT_W;
  localparam int PROD_W     = RSIZE_W + QIDX_W;
  localparam int SIZE_ROUND = 3;

  // Configuration port
  localparam int DATA_W  = 32;
  localparam int PADDR_W = 4;

  localparam logic [1:0] REG_BASE  = 2'd0;
  localparam logic [1:0] REG_SIZE  = 2'd1;
  localparam logic [1:0] REG_COUNT = 2'd2;

  localparam logic [ADDR_W-1:0]  BASE_RESET  = '0;
  localparam logic [SIZE_W-1:0]  SIZE_RESET  = 17'd4;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd1;

  // Item kinds
  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE  = 2'd1;
  localparam logic [1:0] KIND_INIT  = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_ILLEGAL = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic       load_item;
    logic       rd_issue;
    logic       mul_capture;
    logic       alloc_commit;
    logic       free_prep;
    logic       div_start;
    logic       free_commit;
    logic       init_start;
    logic       init_write;
    logic       init_finish;
    logic       set_status;
    logic [1:0] status_code;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] kind;
    logic       queue_empty;
    logic       range_bad;
    logic       div_done;
    logic       rem_nonzero;
    logic       pool_full;
    logic       init_last;
    logic       count_zero;
  } dp_stat_t;

  // Round the requested size up to a multiple of four; zero counts as one byte
  function automatic logic [RSIZE_W-1:0] round_size(input logic [SIZE_W-1:0] s);
    logic [RSIZE_W-1:0] t;
    t = (s == '0) ? RSIZE_W'(1) : {1'b0, s};
    t = t + RSIZE_W'(SIZE_ROUND);
    return {t[RSIZE_W-1:2], 2'b00};
  endfunction

  // Clamp the configured count to the pool capacity
  function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] c);
    return (c > COUNT_W'(MAX_BLOCKS)) ? COUNT_W'(MAX_BLOCKS) : c;
  endfunction

endpackage

/* rtl/fbpa_div.sv */
// ----------------------------------------------------------------------------
// fbpa_div: restoring divider for block index and alignment check
// Divides a pool offset by the rounded block size, one quotient bit per
// cycle. The offset is known to be below size times MAX_BLOCKS, so the
// quotient fits a block index.
// ----------------------------------------------------------------------------
module fbpa_div
  import fbpa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [OFS_W-1:0]   dividend,
  input  logic [RSIZE_W-1:0] divisor,
  output logic               done,
  output logic [QIDX_W-1:0]  quotient,
  output logic               rem_nonzero
);

  localparam int STEP_W = $clog2(QIDX_W);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [OFS_W-1:0]  rem;
  logic [OFS_W-1:0]  dsh;
  logic [QIDX_W-1:0] q;

  // Control: busy flag, step counter, done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(QIDX_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: subtract the shifted divisor where it fits, then shift it down
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend;
      dsh <= OFS_W'(divisor) << (QIDX_W - 1);
      q   <= '0;
    end else if (busy) begin
      if (rem >= dsh) begin
        rem <= rem - dsh;
        q   <= {q[QIDX_W-2:0], 1'b1};
      end else begin
        q   <= {q[QIDX_W-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
  end

  assign quotient    = q;
  assign rem_nonzero = (rem != '0);

endmodule

/* rtl/fbpa_dp.sv */
// ----------------------------------------------------------------------------
// fbpa_dp: allocator datapath
// Free queue memory with head/tail pointers and free count, address
// arithmetic for allocate, range and alignment checks for free, and the
// fill sweep for initialize. Acts only on controller commands.
// ----------------------------------------------------------------------------
module fbpa_dp
  import fbpa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  input  logic [1:0]         item_kind,
  input  logic [ADDR_W-1:0]  item_address,
  input  logic [ADDR_W-1:0]  base_address,
  input  logic [SIZE_W-1:0]  block_size,
  input  logic [COUNT_W-1:0] block_count,
  output dp_stat_t           stat,
  output logic [1:0]         res_status,
  output logic [ADDR_W-1:0]  res_address,
  output logic [COUNT_W-1:0] blocks_free
);

  logic [RSIZE_W-1:0] size;
  logic [COUNT_W-1:0] count;

  logic [1:0]         kind_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [QIDX_W-1:0]  head;
  logic [QIDX_W-1:0]  tail;
  logic [QIDX_W-1:0]  free_queue [MAX_BLOCKS];
  logic [QIDX_W-1:0]  rd_data;
  logic [PROD_W-1:0]  product;
  logic [ADDR_W-1:0]  offset;
  logic [SPAN_W-1:0]  span;
  logic [COUNT_W-1:0] init_cnt;

  logic               div_done;
  logic [QIDX_W-1:0]  div_q;
  logic               div_rem_nz;

  assign size  = round_size(block_size);
  assign count = eff_count(block_count);

  // Capture the item
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      kind_q <= item_kind;
      addr_q <= item_address;
    end
  end

  // Queue pointers and free count
  always_ff @(posedge clk) begin
    if (rst) begin
      head        <= '0;
      tail        <= '0;
      blocks_free <= '0;
    end else if (cmd.init_finish) begin
      head        <= '0;
      tail        <= count[QIDX_W-1:0];
      blocks_free <= count;
    end else if (cmd.alloc_commit) begin
      head        <= head + QIDX_W'(1);
      blocks_free <= blocks_free - COUNT_W'(1);
    end else if (cmd.free_commit) begin
      tail        <= tail + QIDX_W'(1);
      blocks_free <= blocks_free + COUNT_W'(1);
    end
  end

  // Free queue memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.init_write) begin
      free_queue[init_cnt[QIDX_W-1:0]] <= init_cnt[QIDX_W-1:0];
    end else if (cmd.free_commit) begin
      free_queue[tail] <= div_q;
    end
    if (cmd.rd_issue) begin
      rd_data <= free_queue[head];
    end
  end

  // Fill sweep counter
  always_ff @(posedge clk) begin
    if (cmd.init_start) begin
      init_cnt <= '0;
    end else if (cmd.init_write) begin
      init_cnt <= init_cnt + COUNT_W'(1);
    end
  end

  // Address arithmetic
  always_ff @(posedge clk) begin
    if (cmd.mul_capture) begin
      product <= size * rd_data;
    end
    if (cmd.free_prep) begin
      offset <= addr_q - base_address;
      span   <= size * count;
    end
  end

  // Result fields
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      res_status  <= ST_OK;
      res_address <= '0;
    end else begin
      if (cmd.set_status) begin
        res_status <= cmd.status_code;
      end
      if (cmd.alloc_commit) begin
        res_address <= base_address + ADDR_W'(product);
      end
    end
  end

  fbpa_div u_div (
    .clk         (clk),
    .rst         (rst),
    .start       (cmd.div_start),
    .dividend    (offset[OFS_W-1:0]),
    .divisor     (size),
    .done        (div_done),
    .quotient    (div_q),
    .rem_nonzero (div_rem_nz)
  );

  // Status toward the controller
  always_comb begin
    stat.kind        = kind_q;
    stat.queue_empty = (blocks_free == '0);
    stat.range_bad   = (addr_q == '0) || (offset >= ADDR_W'(span));
    stat.div_done    = div_done;
    stat.rem_nonzero = div_rem_nz;
    stat.pool_full   = (blocks_free >= count);
    stat.init_last   = (init_cnt == count - COUNT_W'(1));
    stat.count_zero  = (count == '0);
  end

  // Pointer distance tracks the free count
  a_ptr_consistent: assert property (@(posedge clk) disable iff (rst)
    blocks_free[QIDX_W-1:0] == QIDX_W'(tail - head))
    else $error("queue pointers disagree with free count");

  // Never pop an empty queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.alloc_commit |-> blocks_free != '0)
    else $error("allocate committed with no free block");

  // Push only aligned blocks into a queue that has room
  a_push_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.free_commit |-> (blocks_free < count) && !div_rem_nz)
    else $error("free committed while full or unaligned");

endmodule

/* rtl/fbpa_ctrl.sv */
// ----------------------------------------------------------------------------
// fbpa_ctrl: allocator controller
// Sequences one item at a time through the datapath: dispatch on kind,
// run allocate, free or initialize steps, then hand the result to the
// output register.
// ----------------------------------------------------------------------------
module fbpa_ctrl
  import fbpa_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_ready,
  input  logic     out_space,
  output logic     out_load,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_DISPATCH  = 3'd1;
  localparam logic [2:0] S_ALLOC_RD  = 3'd2;
  localparam logic [2:0] S_ALLOC_ADD = 3'd3;
  localparam logic [2:0] S_FREE_CHK  = 3'd4;
  localparam logic [2:0] S_FREE_DIV  = 3'd5;
  localparam logic [2:0] S_INIT      = 3'd6;
  localparam logic [2:0] S_DONE      = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command decode
  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.kind)
          KIND_ALLOC: begin
            if (stat.queue_empty) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_EMPTY;
              state_next      = S_DONE;
            end else begin
              cmd.rd_issue = 1'b1;
              state_next   = S_ALLOC_RD;
            end
          end
          KIND_FREE: begin
            cmd.free_prep = 1'b1;
            state_next    = S_FREE_CHK;
          end
          KIND_INIT: begin
            cmd.init_start = 1'b1;
            state_next     = S_INIT;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_ALLOC_RD: begin
        cmd.mul_capture = 1'b1;
        state_next      = S_ALLOC_ADD;
      end
      S_ALLOC_ADD: begin
        cmd.alloc_commit = 1'b1;
        state_next       = S_DONE;
      end
      S_FREE_CHK: begin
        if (stat.range_bad) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_ILLEGAL;
          state_next      = S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_FREE_DIV;
        end
      end
      S_FREE_DIV: begin
        // Alignment is judged before fullness
        if (stat.div_done) begin
          if (stat.rem_nonzero) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = ST_ILLEGAL;
          end else if (stat.pool_full) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = ST_FULL;
          end else begin
            cmd.free_commit = 1'b1;
          end
          state_next = S_DONE;
        end
      end
      S_INIT: begin
        if (stat.count_zero) begin
          cmd.init_finish = 1'b1;
          state_next      = S_DONE;
        end else begin
          cmd.init_write = 1'b1;
          if (stat.init_last) begin
            cmd.init_finish = 1'b1;
            state_next      = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (out_space) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/fixed_block_pool_allocator.sv */
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator: pool of equal-size blocks with a FIFO free list
// Usage:
//   Configure base_address, block_size and block_count over the APB port
//   (byte addresses 0, 4, 8) while the block is idle, then send an
//   initialize item to mark every block free in index order.
//   Each item on the item channel (kind, address) gives exactly one result
//   (status, block_address, free_count) on the result channel.
//   With the result side free, each item passes dispatch and ends in the
//   done state, from which the controller returns to idle for the next
//   item. Allocate reads the queue (unless empty), multiplies and adds;
//   free checks the range and, if in range, waits on the divider, which
//   finds the block index one quotient bit at a time; initialize makes
//   one queue write per block; one item is worked on at a time.
//   A finished result waits in the output register while the next item is
//   accepted and processed; if the receiver stalls, processing halts at the
//   end of that next item until the output register empties.
//   Reset clears the queue pointers and free count (pool empty until
//   initialized) and sets the registers to base 0, size 4, count 1.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator
  import fbpa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  // Item channel
  input  logic               item_valid,
  output logic               item_ready,
  input  logic [1:0]         kind,
  input  logic [ADDR_W-1:0]  address,
  // Result channel
  output logic               result_valid,
  input  logic               result_ready,
  output logic [1:0]         status,
  output logic [ADDR_W-1:0]  block_address,
  output logic [COUNT_W-1:0] free_count
);

  logic [ADDR_W-1:0]  base_address;
  logic [SIZE_W-1:0]  block_size;
  logic [COUNT_W-1:0] block_count;
  logic               cfg_write;
  logic [1:0]         reg_index;

  dp_cmd_t            cmd;
  dp_stat_t           stat;
  logic               out_space;
  logic               out_load;
  logic [1:0]         res_status;
  logic [ADDR_W-1:0]  res_address;
  logic [COUNT_W-1:0] blocks_free;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_index = paddr[PADDR_W-1:2];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= BASE_RESET;
      block_size   <= SIZE_RESET;
      block_count  <= COUNT_RESET;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_BASE:  base_address <= pwdata[ADDR_W-1:0];
        REG_SIZE:  block_size   <= pwdata[SIZE_W-1:0];
        REG_COUNT: block_count  <= pwdata[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (reg_index)
      REG_BASE:  prdata = DATA_W'(base_address);
      REG_SIZE:  prdata = DATA_W'(block_size);
      REG_COUNT: prdata = DATA_W'(block_count);
      default:   prdata = '0;
    endcase
  end

  fbpa_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .out_space  (out_space),
    .out_load   (out_load),
    .stat       (stat),
    .cmd        (cmd)
  );

  fbpa_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .item_kind    (kind),
    .item_address (address),
    .base_address (base_address),
    .block_size   (block_size),
    .block_count  (block_count),
    .stat         (stat),
    .res_status   (res_status),
    .res_address  (res_address),
    .blocks_free  (blocks_free)
  );

  // Output register: hold the result until the receiver takes it
  assign out_space = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status        <= res_status;
      block_address <= res_address;
      free_count    <= blocks_free;
    end
  end

endmodule
